### rtl/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg
// Types, constants and helper functions shared by the tag trigram counter.
// ----------------------------------------------------------------------------
package ttc_pkg;

   localparam int NUM_TAGS    = 32;
   localparam int COUNT_BITS  = 24;
   localparam int TOTAL_BITS  = 32;
   localparam int TAG_BITS    = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
   localparam int PAIR_BITS   = 2 * TAG_BITS;
   localparam int TRI_BITS    = 3 * TAG_BITS;
   localparam int PAIR_DEPTH  = 1 << PAIR_BITS;
   localparam int TRI_DEPTH   = 1 << TRI_BITS;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [TOTAL_BITS-1:0] total_type;
   typedef logic [TAG_BITS-1:0]   tag_type;

   typedef struct packed {
      logic [4:0] tag;
      logic       sentence_end;
   } ttc_req_type;

   typedef struct packed {
      logic [23:0] unigram_count;
      logic [23:0] bigram_count;
      logic [23:0] trigram_count;
      logic        unigram_new;
      logic        bigram_new;
      logic        trigram_new;
      logic [31:0] unigram_total;
      logic [31:0] bigram_total;
      logic [31:0] trigram_total;
      logic [31:0] unigram_distinct;
      logic [31:0] bigram_distinct;
      logic [31:0] trigram_distinct;
   } ttc_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic read;
      logic commit;
   } ttc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
   } ttc_sts_type;

   function automatic count_type sat_count(input count_type value);
      sat_count = (&value) ? value : value + count_type'(1);
   endfunction

   function automatic total_type sat_total(input total_type value, input logic enable);
      sat_total = (enable && !(&value)) ? value + total_type'(1) : value;
   endfunction

endpackage

### rtl/ttc_ctrl.sv
// ----------------------------------------------------------------------------
// ttc_ctrl
// Sequencer: memory clearing pass, transaction accept, read, update, and the
// result valid flag.
// ----------------------------------------------------------------------------
module ttc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ttc_pkg::ttc_sts_type sts,
   output ttc_pkg::ttc_cmd_type cmd
);
   import ttc_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit;

   // update may proceed once the output register is free or being drained
   assign commit    = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.read   = (state_ff == ST_READ);
      cmd.commit = commit;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid)      state_in = ST_READ;
         ST_READ:                       state_in = ST_UPDATE;
         ST_UPDATE: if (commit)         state_in = ST_IDLE;
         default:                       state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      priority if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/ttc_datapath.sv
// ----------------------------------------------------------------------------
// ttc_datapath
// Count memories, sentence history, saturating totals and the result register.
// ----------------------------------------------------------------------------
module ttc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ttc_pkg::ttc_cmd_type cmd,
   output ttc_pkg::ttc_sts_type sts,
   input  ttc_pkg::ttc_req_type req_data,
   output ttc_pkg::ttc_rsp_type rsp_data
);
   import ttc_pkg::*;

   count_type uni_mem  [NUM_TAGS];
   count_type pair_mem [PAIR_DEPTH];
   count_type tri_mem  [TRI_DEPTH];

   logic [TRI_BITS-1:0] clr_addr_ff;

   tag_type   cur_ff, prev_ff, prev2_ff;
   logic      last_ff;
   logic [1:0] pos_ff;

   count_type uni_rd_ff, pair_rd_ff, tri_rd_ff;
   total_type uni_total_ff, pair_total_ff, tri_total_ff;
   total_type uni_dist_ff, pair_dist_ff, tri_dist_ff;
   ttc_rsp_type rsp_ff;

   tag_type             cur_in;
   logic [PAIR_BITS-1:0] pair_addr;
   logic [TRI_BITS-1:0]  tri_addr;
   logic      pair_en, tri_en;
   logic      uni_new, pair_new, tri_new;
   count_type uni_next, pair_next, tri_next;
   total_type uni_total_in, pair_total_in, tri_total_in;
   total_type uni_dist_in, pair_dist_in, tri_dist_in;

   // out-of-range tags fold onto the last tag
   assign cur_in = (int'(req_data.tag) >= NUM_TAGS) ? tag_type'(NUM_TAGS - 1)
                                                     : tag_type'(req_data.tag);

   assign pair_addr = {prev_ff, cur_ff};
   assign tri_addr  = {prev2_ff, prev_ff, cur_ff};
   assign pair_en   = (pos_ff != 2'd0);
   assign tri_en    = pos_ff[1];

   assign uni_new   = (uni_rd_ff == '0);
   assign pair_new  = pair_en && (pair_rd_ff == '0);
   assign tri_new   = tri_en && (tri_rd_ff == '0);
   assign uni_next  = sat_count(uni_rd_ff);
   assign pair_next = sat_count(pair_rd_ff);
   assign tri_next  = sat_count(tri_rd_ff);

   assign uni_total_in  = sat_total(uni_total_ff, 1'b1);
   assign pair_total_in = sat_total(pair_total_ff, pair_en);
   assign tri_total_in  = sat_total(tri_total_ff, tri_en);
   assign uni_dist_in   = sat_total(uni_dist_ff, uni_new);
   assign pair_dist_in  = sat_total(pair_dist_ff, pair_new);
   assign tri_dist_in   = sat_total(tri_dist_ff, tri_new);

   assign sts.clear_done = &clr_addr_ff;
   assign rsp_data       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // memories: zero during the clearing pass, write back on update
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         uni_mem[clr_addr_ff[TAG_BITS-1:0]] <= '0;
      end else if (cmd.commit) begin
         uni_mem[cur_ff] <= uni_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         pair_mem[clr_addr_ff[PAIR_BITS-1:0]] <= '0;
      end else if (cmd.commit && pair_en) begin
         pair_mem[pair_addr] <= pair_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         tri_mem[clr_addr_ff] <= '0;
      end else if (cmd.commit && tri_en) begin
         tri_mem[tri_addr] <= tri_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         uni_rd_ff  <= uni_mem[cur_ff];
         pair_rd_ff <= pair_mem[pair_addr];
         tri_rd_ff  <= tri_mem[tri_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff  <= cur_in;
         last_ff <= req_data.sentence_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         prev2_ff      <= '0;
         pos_ff        <= 2'd0;
         uni_total_ff  <= '0;
         pair_total_ff <= '0;
         tri_total_ff  <= '0;
         uni_dist_ff   <= '0;
         pair_dist_ff  <= '0;
         tri_dist_ff   <= '0;
      end else if (cmd.commit) begin
         uni_total_ff  <= uni_total_in;
         pair_total_ff <= pair_total_in;
         tri_total_ff  <= tri_total_in;
         uni_dist_ff   <= uni_dist_in;
         pair_dist_ff  <= pair_dist_in;
         tri_dist_ff   <= tri_dist_in;
         if (last_ff) begin
            prev_ff  <= '0;
            prev2_ff <= '0;
            pos_ff   <= 2'd0;
         end else begin
            prev2_ff <= prev_ff;
            prev_ff  <= cur_ff;
            if (!pos_ff[1]) pos_ff <= pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.unigram_count    <= 24'(uni_next);
         rsp_ff.bigram_count     <= pair_en ? 24'(pair_next) : '0;
         rsp_ff.trigram_count    <= tri_en ? 24'(tri_next) : '0;
         rsp_ff.unigram_new      <= uni_new;
         rsp_ff.bigram_new       <= pair_new;
         rsp_ff.trigram_new      <= tri_new;
         rsp_ff.unigram_total    <= uni_total_in;
         rsp_ff.bigram_total     <= pair_total_in;
         rsp_ff.trigram_total    <= tri_total_in;
         rsp_ff.unigram_distinct <= uni_dist_in;
         rsp_ff.bigram_distinct  <= pair_dist_in;
         rsp_ff.trigram_distinct <= tri_dist_in;
      end
   end

endmodule

### rtl/tag_trigram_counter_unit.sv
// ----------------------------------------------------------------------------
// tag_trigram_counter_unit
// Unigram, bigram and trigram frequency counter over a stream of tag indices.
// ----------------------------------------------------------------------------
// Each accepted transaction carries one tag and a sentence-end flag and yields
// one result: the updated saturating counts of the unigram, bigram and trigram
// ending at this tag, their new-entry flags, and the running totals and
// distinct counts per order. After reset the block zeroes its count memories
// in a clearing pass over all 32768 trigram entries, one entry per cycle, and
// holds req_stall high meanwhile. Each tag then passes accept, memory read,
// and update with write-back, set by the read-modify-write of the count
// memories, which serves one tag at a time. The next tag is taken while the
// previous result waits in the output register; its update waits until that drains.
module tag_trigram_counter_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ttc_pkg::ttc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ttc_pkg::ttc_rsp_type rsp_data
);
   import ttc_pkg::*;

   ttc_cmd_type cmd;
   ttc_sts_type sts;

   ttc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ttc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
